// ===== sv/qcs_pkg.sv =====
// ----------------------------------------------------------------------------
// qcs_pkg
// Shared codes and field widths of the quadtree colour segmentation unit.
// ----------------------------------------------------------------------------
package qcs_pkg;

    localparam int ACT_W   = 2;
    localparam int COORD_W = 8;
    localparam int COL_W   = 8;
    localparam int SIDE_W  = 9;
    localparam int CFG_W   = 9;
    localparam int CIDX_W  = 2;

    // action codes
    localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_START = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FETCH = 2'd2;
    localparam logic [ACT_W-1:0] ACT_NOP   = 2'd3;

    // register indexes
    localparam logic [CIDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_MIN_LEAF     = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_DEV_THRESH   = 2'd3;

endpackage

// ===== sv/qcs_in_if.sv =====
// ----------------------------------------------------------------------------
// qcs_in_if
// Command channel: pixel loads, start and leaf fetch commands.
// ----------------------------------------------------------------------------
interface qcs_in_if import qcs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ACT_W-1:0]   action;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [COL_W-1:0]   red_in;
    logic [COL_W-1:0]   green_in;
    logic [COL_W-1:0]   blue_in;

    modport source (output valid, action, pixel_x, pixel_y, red_in, green_in, blue_in,
                    input ready);
    modport sink   (input valid, action, pixel_x, pixel_y, red_in, green_in, blue_in,
                    output ready);
endinterface

// ===== sv/qcs_out_if.sv =====
// ----------------------------------------------------------------------------
// qcs_out_if
// Result channel: one leaf region with its mean colour per fetch.
// ----------------------------------------------------------------------------
interface qcs_out_if import qcs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               leaf_valid;
    logic [COORD_W-1:0] leaf_x;
    logic [COORD_W-1:0] leaf_y;
    logic [SIDE_W-1:0]  leaf_width;
    logic [SIDE_W-1:0]  leaf_height;
    logic [COL_W-1:0]   mean_red;
    logic [COL_W-1:0]   mean_green;
    logic [COL_W-1:0]   mean_blue;
    logic               all_done;

    modport source (output valid, leaf_valid, leaf_x, leaf_y, leaf_width, leaf_height,
                    mean_red, mean_green, mean_blue, all_done, input ready);
    modport sink   (input valid, leaf_valid, leaf_x, leaf_y, leaf_width, leaf_height,
                    mean_red, mean_green, mean_blue, all_done, output ready);
endinterface

// ===== sv/quadtree_color_segmentation_unit.sv =====
// ----------------------------------------------------------------------------
// quadtree_color_segmentation_unit
// Image store plus depth-first quadtree split on colour deviation.
// ----------------------------------------------------------------------------
// Load pixels with action 0 (no result), issue start (action 1, no result)
// to place the whole image on the region stack, then fetch (action 2) one
// leaf per item until all_done is set. A fetch visits regions until it
// reaches a leaf: each region is first popped and scanned, one pixel per
// cycle through the single read port of the pixel store. A region that may
// split then runs the shared shift/add unit: a shift-add multiply for n*n,
// and per colour channel shift-add multiplies for n times the sum of squares
// and for the square of the sum, restoring division and square root, then a
// decision and a push of the four children. The leaf finally gets its three
// mean colours by division and then presents the result. The pixel store has
// no reset and no clearing pass; read only pixels that were loaded. The block
// takes a new command while a result still waits on the output channel.
// ----------------------------------------------------------------------------
module quadtree_color_segmentation_unit import qcs_pkg::*; #(
    parameter int MAX_SIDE    = 256,
    parameter int STACK_DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    qcs_in_if.sink             i_in,
    qcs_out_if.source          o_out,
    input  logic               i_cfg_we,
    input  logic [CIDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data
);

    // widths derived from the image and stack sizes
    localparam int CW   = $clog2(MAX_SIDE);
    localparam int SW   = $clog2(MAX_SIDE + 1);
    localparam int AD   = $clog2(MAX_SIDE * MAX_SIDE);
    localparam int NW   = $clog2(MAX_SIDE * MAX_SIDE + 1);
    localparam int SUMW = NW + 8;
    localparam int SQW  = NW + 16;
    localparam int AW   = 2 * NW + 32;
    localparam int KMAX = (SUMW > 32) ? SUMW : 32;
    localparam int KW   = $clog2(KMAX);
    localparam int SIW  = $clog2(STACK_DEPTH);
    localparam int DPW  = $clog2(STACK_DEPTH + 1);

    // sequencer states
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_POP    = 4'd1;
    localparam logic [3:0] ST_GRAB   = 4'd2;
    localparam logic [3:0] ST_SCAN   = 4'd3;
    localparam logic [3:0] ST_DRAIN  = 4'd4;
    localparam logic [3:0] ST_CHECK  = 4'd5;
    localparam logic [3:0] ST_MULM   = 4'd6;
    localparam logic [3:0] ST_MULQ   = 4'd7;
    localparam logic [3:0] ST_MULS   = 4'd8;
    localparam logic [3:0] ST_DIV    = 4'd9;
    localparam logic [3:0] ST_SQRT   = 4'd10;
    localparam logic [3:0] ST_DECIDE = 4'd11;
    localparam logic [3:0] ST_PUSH   = 4'd12;
    localparam logic [3:0] ST_MEAN   = 4'd13;
    localparam logic [3:0] ST_FIN    = 4'd14;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [SW-1:0] w;
        logic [SW-1:0] h;
    } t_region;

    // saturate a size register to 1..MAX_SIDE
    function automatic logic [SW-1:0] side_of(input logic [CFG_W-1:0] v);
        logic [SW-1:0] s;
        if (v == '0) begin
            s = SW'(1);
        end else if (32'(v) > MAX_SIDE) begin
            s = SW'(MAX_SIDE);
        end else begin
            s = SW'(v);
        end
        return s;
    endfunction

    // configuration
    logic [CFG_W-1:0] r_img_w, r_img_h, r_mls;
    logic [6:0]       r_thr;

    // control
    logic [3:0]     r_state, n_state;
    logic [DPW-1:0] r_depth;
    logic           r_ov;
    logic           r_rdv;
    logic           r_lv;
    logic [1:0]     r_pc;
    logic [1:0]     r_ch;
    logic [KW-1:0]  r_k;

    // region and scan
    t_region        r_g;
    t_region        r_stk_q;
    t_region        stack [STACK_DEPTH];
    logic [CW-1:0]  r_i, r_j;
    logic [NW-1:0]  r_n;
    logic [SUMW-1:0] r_sum [3];
    logic [SQW-1:0]  r_sq  [3];
    logic [23:0]    mem [MAX_SIDE * MAX_SIDE];
    logic [23:0]    r_pix_q;

    // shared arithmetic unit
    logic [AW-1:0]   r_acc, r_sh;
    logic [SUMW-1:0] r_mb;
    logic [2*NW-1:0] r_m;
    logic [31:0]     r_quot, r_res, r_bit;
    logic [17:0]     r_tot;
    logic [7:0]      r_mq;
    logic [7:0]      r_mean [3];

    // result registers
    logic               r_o_lv, r_o_done;
    logic [COORD_W-1:0] r_o_x, r_o_y;
    logic [SIDE_W-1:0]  r_o_w, r_o_h;
    logic [COL_W-1:0]   r_o_r, r_o_gr, r_o_b;

    logic          in_acc;
    logic [AW-1:0] opnd;
    logic          alu_sub;
    logic [AW:0]   alu;
    logic          ge;
    logic [AW-1:0] mul_acc;
    logic [31:0]   sq_res;
    logic [CW-1:0] x_end, y_end;
    logic          scan_last;
    logic          leaf_early;
    logic [AD-1:0] rd_addr;
    logic [SW-1:0] w2, h2;
    t_region       child;
    logic          stk_we;
    logic [SIW-1:0] stk_wa;
    t_region       stk_wd;
    logic [1:0]    ch_nx;

    assign in_acc      = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign ch_nx       = r_ch + 2'd1;

    // one adder serves multiply, division, square root and mean
    always_comb begin
        opnd    = (r_state == ST_SQRT) ? AW'({1'b0, r_res} + {1'b0, r_bit}) : r_sh;
        alu_sub = !(r_state == ST_MULM || r_state == ST_MULQ);
        alu     = {1'b0, r_acc} + ({1'b0, opnd} ^ {(AW+1){alu_sub}}) + (AW+1)'(alu_sub);
        ge      = !alu[AW];
        mul_acc = r_mb[0] ? alu[AW-1:0] : r_acc;
        sq_res  = ge ? ((r_res >> 1) + r_bit) : (r_res >> 1);
    end

    // scan bounds and early leaf test
    always_comb begin
        x_end      = CW'(r_g.x + r_g.w - 1'b1);
        y_end      = CW'(r_g.y + r_g.h - 1'b1);
        scan_last  = (r_i == x_end) && (r_j == y_end);
        rd_addr    = AD'(32'(r_j) * MAX_SIDE + 32'(r_i));
        w2         = r_g.w >> 1;
        h2         = r_g.h >> 1;
        leaf_early = (32'(r_g.w) <= 32'(r_mls)) || (32'(r_g.h) <= 32'(r_mls)) ||
                     (w2 == '0) || (h2 == '0) || (32'(r_depth) + 4 > STACK_DEPTH);
    end

    // children in push order SE, SW, NE, NW so that NW pops first
    always_comb begin
        child = r_g;
        case (r_pc)
            2'd0: begin
                child.x = CW'(r_g.x + w2); child.y = CW'(r_g.y + h2);
                child.w = r_g.w - w2;      child.h = r_g.h - h2;
            end
            2'd1: begin
                child.y = CW'(r_g.y + h2);
                child.w = w2;              child.h = r_g.h - h2;
            end
            2'd2: begin
                child.x = CW'(r_g.x + w2);
                child.w = r_g.w - w2;      child.h = h2;
            end
            default: begin
                child.w = w2;              child.h = h2;
            end
        endcase
    end

    // stack write port: root on start, children while splitting
    always_comb begin
        stk_we = 1'b0;
        stk_wa = SIW'(r_depth);
        stk_wd = child;
        if (r_state == ST_IDLE && in_acc && i_in.action == ACT_START) begin
            stk_we = 1'b1;
            stk_wa = '0;
            stk_wd = '{x: '0, y: '0, w: side_of(r_img_w), h: side_of(r_img_h)};
        end else if (r_state == ST_PUSH) begin
            stk_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            stack[stk_wa] <= stk_wd;
        end
        r_stk_q <= stack[SIW'(r_depth - 1'b1)];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && in_acc && i_in.action == ACT_LOAD &&
            32'(i_in.pixel_x) < MAX_SIDE && 32'(i_in.pixel_y) < MAX_SIDE) begin
            mem[AD'(32'(i_in.pixel_y) * MAX_SIDE + 32'(i_in.pixel_x))] <=
                {i_in.red_in, i_in.green_in, i_in.blue_in};
        end
        r_pix_q <= mem[rd_addr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && i_in.action == ACT_FETCH) begin
                    n_state = (r_depth == '0) ? ST_FIN : ST_POP;
                end
            end
            ST_POP:    n_state = ST_GRAB;
            ST_GRAB:   n_state = ST_SCAN;
            ST_SCAN:   n_state = scan_last ? ST_DRAIN : ST_SCAN;
            ST_DRAIN:  n_state = ST_CHECK;
            ST_CHECK:  n_state = leaf_early ? ST_MEAN : ST_MULM;
            ST_MULM:   n_state = (r_k == KW'(NW - 1)) ? ST_MULQ : ST_MULM;
            ST_MULQ:   n_state = (r_k == KW'(NW - 1)) ? ST_MULS : ST_MULQ;
            ST_MULS:   n_state = (r_k == KW'(SUMW - 1)) ? ST_DIV : ST_MULS;
            ST_DIV:    n_state = (r_k == KW'(31)) ? ST_SQRT : ST_DIV;
            ST_SQRT: begin
                if (r_k == KW'(15)) begin
                    n_state = (r_ch == 2'd2) ? ST_DECIDE : ST_MULQ;
                end
            end
            ST_DECIDE: n_state = (r_tot <= 18'(r_thr) * 18'd768) ? ST_MEAN : ST_PUSH;
            ST_PUSH:   n_state = (r_pc == 2'd3) ? ST_POP : ST_PUSH;
            ST_MEAN: begin
                if (r_k == KW'(7) && r_ch == 2'd2) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN:    n_state = (!r_ov || o_out.ready) ? ST_IDLE : ST_FIN;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_depth <= '0;
            r_ov    <= 1'b0;
            r_rdv   <= 1'b0;
            r_img_w <= CFG_W'(256);
            r_img_h <= CFG_W'(256);
            r_mls   <= CFG_W'(1);
            r_thr   <= 7'd8;
        end else begin
            r_state <= n_state;
            r_rdv   <= (r_state == ST_SCAN);
            // present a new result, or drop the one just taken
            if (r_state == ST_FIN && (!r_ov || o_out.ready)) begin
                r_ov <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_IMAGE_WIDTH:  r_img_w <= i_cfg_data;
                    CFG_IMAGE_HEIGHT: r_img_h <= i_cfg_data;
                    CFG_MIN_LEAF:     r_mls   <= i_cfg_data;
                    CFG_DEV_THRESH:   r_thr   <= i_cfg_data[6:0];
                    default:          r_thr   <= r_thr;
                endcase
            end
            // accumulate the pixel read in the previous cycle
            if (r_rdv) begin
                r_sum[0] <= r_sum[0] + SUMW'(r_pix_q[23:16]);
                r_sum[1] <= r_sum[1] + SUMW'(r_pix_q[15:8]);
                r_sum[2] <= r_sum[2] + SUMW'(r_pix_q[7:0]);
                r_sq[0]  <= r_sq[0] + SQW'(16'(r_pix_q[23:16] * r_pix_q[23:16]));
                r_sq[1]  <= r_sq[1] + SQW'(16'(r_pix_q[15:8] * r_pix_q[15:8]));
                r_sq[2]  <= r_sq[2] + SQW'(16'(r_pix_q[7:0] * r_pix_q[7:0]));
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc && i_in.action == ACT_START) begin
                        r_depth <= DPW'(1);
                    end
                    if (in_acc && i_in.action == ACT_FETCH) begin
                        r_lv <= (r_depth != '0);
                    end
                end
                ST_POP: begin
                    r_depth <= r_depth - 1'b1;
                end
                ST_GRAB: begin
                    r_g   <= r_stk_q;
                    r_i   <= r_stk_q.x;
                    r_j   <= r_stk_q.y;
                    r_n   <= NW'(r_stk_q.w * r_stk_q.h);
                    r_sum <= '{default: '0};
                    r_sq  <= '{default: '0};
                end
                ST_SCAN: begin
                    if (r_i == x_end) begin
                        r_i <= r_g.x;
                        r_j <= r_j + 1'b1;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                ST_CHECK: begin
                    r_k   <= '0;
                    r_ch  <= 2'd0;
                    r_tot <= '0;
                    r_mq  <= '0;
                    if (leaf_early) begin
                        r_acc <= AW'(r_sum[0]);
                        r_sh  <= AW'(r_n) << 7;
                    end else begin
                        r_acc <= '0;
                        r_sh  <= AW'(r_n);
                        r_mb  <= SUMW'(r_n);
                    end
                end
                ST_MULM, ST_MULQ, ST_MULS: begin
                    r_acc <= mul_acc;
                    r_sh  <= r_sh << 1;
                    r_mb  <= r_mb >> 1;
                    r_k   <= r_k + 1'b1;
                    if (r_state == ST_MULM && r_k == KW'(NW - 1)) begin
                        // keep n*n, then start n*q for the first channel
                        r_m   <= (2*NW)'(mul_acc);
                        r_acc <= '0;
                        r_sh  <= AW'(r_sq[r_ch]);
                        r_mb  <= SUMW'(r_n);
                        r_k   <= '0;
                    end
                    if (r_state == ST_MULQ && r_k == KW'(NW - 1)) begin
                        r_sh <= AW'(r_sum[r_ch]);
                        r_mb <= r_sum[r_ch];
                        r_k  <= '0;
                    end
                    if (r_state == ST_MULS && r_k == KW'(SUMW - 1)) begin
                        // divide (n*q - s*s) * 2^16 by n*n
                        r_acc  <= mul_acc << 16;
                        r_sh   <= AW'(r_m) << 31;
                        r_quot <= '0;
                        r_k    <= '0;
                    end
                end
                ST_DIV: begin
                    if (ge) begin
                        r_acc <= alu[AW-1:0];
                    end
                    r_quot <= {r_quot[30:0], ge};
                    r_sh   <= r_sh >> 1;
                    r_k    <= r_k + 1'b1;
                    if (r_k == KW'(31)) begin
                        r_acc <= AW'({r_quot[30:0], ge});
                        r_res <= '0;
                        r_bit <= 32'h4000_0000;
                        r_k   <= '0;
                    end
                end
                ST_SQRT: begin
                    if (ge) begin
                        r_acc <= alu[AW-1:0];
                    end
                    r_res <= sq_res;
                    r_bit <= r_bit >> 2;
                    r_k   <= r_k + 1'b1;
                    if (r_k == KW'(15)) begin
                        r_tot <= r_tot + 18'(sq_res);
                        r_k   <= '0;
                        if (r_ch != 2'd2) begin
                            r_ch  <= ch_nx;
                            r_acc <= '0;
                            r_sh  <= AW'(r_sq[ch_nx]);
                            r_mb  <= SUMW'(r_n);
                        end
                    end
                end
                ST_DECIDE: begin
                    r_pc  <= 2'd0;
                    r_k   <= '0;
                    r_ch  <= 2'd0;
                    r_mq  <= '0;
                    r_acc <= AW'(r_sum[0]);
                    r_sh  <= AW'(r_n) << 7;
                end
                ST_PUSH: begin
                    r_depth <= r_depth + 1'b1;
                    r_pc    <= r_pc + 2'd1;
                end
                ST_MEAN: begin
                    if (ge) begin
                        r_acc <= alu[AW-1:0];
                    end
                    r_mq <= {r_mq[6:0], ge};
                    r_sh <= r_sh >> 1;
                    r_k  <= r_k + 1'b1;
                    if (r_k == KW'(7)) begin
                        r_mean[r_ch] <= {r_mq[6:0], ge};
                        r_k          <= '0;
                        r_mq         <= '0;
                        if (r_ch != 2'd2) begin
                            r_ch  <= ch_nx;
                            r_acc <= AW'(r_sum[ch_nx]);
                            r_sh  <= AW'(r_n) << 7;
                        end
                    end
                end
                ST_FIN: begin
                    if (!r_ov || o_out.ready) begin
                        r_o_lv   <= r_lv;
                        r_o_done <= (r_depth == '0);
                        r_o_x    <= r_lv ? COORD_W'(r_g.x) : '0;
                        r_o_y    <= r_lv ? COORD_W'(r_g.y) : '0;
                        r_o_w    <= r_lv ? SIDE_W'(r_g.w) : '0;
                        r_o_h    <= r_lv ? SIDE_W'(r_g.h) : '0;
                        r_o_r    <= r_lv ? r_mean[0] : '0;
                        r_o_gr   <= r_lv ? r_mean[1] : '0;
                        r_o_b    <= r_lv ? r_mean[2] : '0;
                    end
                end
                default: begin
                    r_k <= r_k;
                end
            endcase
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.leaf_valid  = r_o_lv;
    assign o_out.leaf_x      = r_o_x;
    assign o_out.leaf_y      = r_o_y;
    assign o_out.leaf_width  = r_o_w;
    assign o_out.leaf_height = r_o_h;
    assign o_out.mean_red    = r_o_r;
    assign o_out.mean_green  = r_o_gr;
    assign o_out.mean_blue   = r_o_b;
    assign o_out.all_done    = r_o_done;

`ifndef NO_ASSERTIONS
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_depth) <= STACK_DEPTH)
        else $error("region stack overflow");

    a_push_to_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PUSH && r_pc == 2'd3) |=> (r_state == ST_POP))
        else $error("split did not return to pop");

    a_scan_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_i >= r_g.x && r_i <= x_end && r_j <= y_end))
        else $error("scan left its region");

    a_empty_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && in_acc && i_in.action == ACT_FETCH && r_depth == '0)
        |=> (r_state == ST_FIN && !r_lv))
        else $error("empty fetch not answered directly");
`endif

endmodule

// ===== test/tb_quadtree_color_segmentation_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quadtree_color_segmentation_unit
// Loads small RGB images, starts the quadtree split and fetches leaves under
// several size, leaf and deviation settings. A scoreboard predicts each leaf
// and its mean colour and checks every result against that prediction. Both
// channels idle at random.
// ----------------------------------------------------------------------------
import qcs_pkg::*;

typedef struct packed {
    logic               leaf_valid;
    logic [COORD_W-1:0] leaf_x;
    logic [COORD_W-1:0] leaf_y;
    logic [SIDE_W-1:0]  leaf_width;
    logic [SIDE_W-1:0]  leaf_height;
    logic [COL_W-1:0]   mean_red;
    logic [COL_W-1:0]   mean_green;
    logic [COL_W-1:0]   mean_blue;
    logic               all_done;
} leaf_t;

typedef struct {
    int unsigned x;
    int unsigned y;
    int unsigned w;
    int unsigned h;
} area_t;

class leaf_scoreboard;
    localparam int SIDE  = 256;
    localparam int DEPTH = 32;

    logic [23:0]  pixels [SIDE*SIDE];
    area_t        regions [DEPTH];
    int unsigned  depth;
    logic [8:0]   img_w, img_h, leaf_min;
    logic [6:0]   dev_thresh;
    leaf_t        pending [$];
    bit           last_done;
    int unsigned  fails;
    int unsigned  commands;

    function new();
        foreach (pixels[i]) pixels[i] = '0;
        depth      = 0;
        img_w      = 9'd256;
        img_h      = 9'd256;
        leaf_min   = 9'd1;
        dev_thresh = 7'd8;
        last_done  = 1'b1;
        fails      = 0;
        commands   = 0;
    endfunction

    function void write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
        case (idx)
            CFG_IMAGE_WIDTH:  img_w = val;
            CFG_IMAGE_HEIGHT: img_h = val;
            CFG_MIN_LEAF:     leaf_min = val;
            CFG_DEV_THRESH:   dev_thresh = val[6:0];
            default: ;
        endcase
    endfunction

    static function int unsigned clamp_side(logic [8:0] v);
        if (v == 0) return 1;
        if (v > SIDE) return SIDE;
        return 32'(v);
    endfunction

    static function longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // floor(256 * population standard deviation)
    static function longint unsigned spread_q8(longint unsigned n, longint unsigned s,
                                               longint unsigned q);
        longint unsigned d, m, vi, r, frac;
        frac = 0;
        if (n == 0 || n * q <= s * s) return 0;
        d  = n * q - s * s;
        m  = n * n;
        vi = d / m;
        r  = d % m;
        for (int i = 0; i < 16; i++) begin
            r <<= 1;
            frac <<= 1;
            if (r >= m) begin
                r -= m;
                frac |= 1;
            end
        end
        return int_sqrt((vi << 16) | frac);
    endfunction

    function void next_leaf();
        leaf_t res;
        area_t g;
        longint unsigned sum [3], sq [3], n, tot, v;
        int unsigned w2, h2;
        bit leaf;
        res = '0;
        res.all_done = 1'b1;
        while (depth > 0 && depth <= DEPTH) begin
            depth--;
            g  = regions[depth];
            n  = g.w * g.h;
            w2 = g.w / 2;
            h2 = g.h / 2;
            for (int c = 0; c < 3; c++) begin
                sum[c] = 0;
                sq[c]  = 0;
            end
            for (int j = g.y; j < g.y + g.h; j++)
                for (int i = g.x; i < g.x + g.w; i++)
                    for (int c = 0; c < 3; c++) begin
                        v = 64'((pixels[(j * SIDE + i) % (SIDE * SIDE)] >> (16 - 8 * c))
                                & 24'hFF);
                        sum[c] += v;
                        sq[c]  += v * v;
                    end
            leaf = g.w <= leaf_min || g.h <= leaf_min;
            if (!leaf) begin
                tot  = spread_q8(n, sum[0], sq[0]) + spread_q8(n, sum[1], sq[1])
                     + spread_q8(n, sum[2], sq[2]);
                leaf = tot <= 3 * 256 * longint'(dev_thresh);
            end
            if (!leaf && (w2 == 0 || h2 == 0)) leaf = 1;
            if (!leaf && depth + 4 > DEPTH) leaf = 1;
            if (leaf) begin
                res.leaf_valid  = 1'b1;
                res.leaf_x      = g.x[7:0];
                res.leaf_y      = g.y[7:0];
                res.leaf_width  = g.w[8:0];
                res.leaf_height = g.h[8:0];
                res.mean_red    = 8'(sum[0] / n);
                res.mean_green  = 8'(sum[1] / n);
                res.mean_blue   = 8'(sum[2] / n);
                res.all_done    = depth == 0;
                pending.push_back(res);
                last_done = res.all_done;
                return;
            end
            // SE, SW, NE, NW: NW comes off first
            regions[depth++] = '{g.x + w2, g.y + h2, g.w - w2, g.h - h2};
            regions[depth++] = '{g.x,      g.y + h2, w2,       g.h - h2};
            regions[depth++] = '{g.x + w2, g.y,      g.w - w2, h2};
            regions[depth++] = '{g.x,      g.y,      w2,       h2};
        end
        depth = 0;
        pending.push_back(res);
        last_done = 1'b1;
    endfunction

    function void note_command(logic [ACT_W-1:0] act, logic [7:0] x, logic [7:0] y,
                               logic [23:0] rgb);
        case (act)
            ACT_LOAD:  pixels[y * SIDE + x] = rgb;
            ACT_START: begin
                regions[0] = '{0, 0, clamp_side(img_w), clamp_side(img_h)};
                depth = 1;
            end
            ACT_FETCH: next_leaf();
            default: ;
        endcase
        if (act != ACT_NOP) commands++;
    endfunction

    function void check_leaf(leaf_t got);
        leaf_t exp;
        if (pending.size() == 0) begin
            fails++;
            if (fails <= 10) $display("unexpected leaf result %p", got);
            return;
        end
        exp = pending.pop_front();
        if (got !== exp) begin
            fails++;
            if (fails <= 10)
                $display("leaf mismatch: expected v%0d x%0d y%0d w%0d h%0d rgb %0d %0d %0d d%0d, got v%0d x%0d y%0d w%0d h%0d rgb %0d %0d %0d d%0d",
                         exp.leaf_valid, exp.leaf_x, exp.leaf_y, exp.leaf_width,
                         exp.leaf_height, exp.mean_red, exp.mean_green, exp.mean_blue,
                         exp.all_done, got.leaf_valid, got.leaf_x, got.leaf_y,
                         got.leaf_width, got.leaf_height, got.mean_red, got.mean_green,
                         got.mean_blue, got.all_done);
        end
    endfunction
endclass

module tb_quadtree_color_segmentation_unit;

    localparam int ITEMS       = 580;
    localparam int CYCLE_LIMIT = 2_500_000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [CIDX_W-1:0] i_cfg_idx = CFG_IMAGE_WIDTH;
    logic [CFG_W-1:0]  i_cfg_data = '0;

    qcs_in_if  cmd_if ();
    qcs_out_if leaf_if ();

    leaf_scoreboard sb = new();
    int unsigned    send_idle_pct = 22;
    int unsigned    take_idle_pct = 78;
    int unsigned    cycles = 0;

    quadtree_color_segmentation_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (cmd_if.sink),
        .o_out      (leaf_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Hold every command input known from time zero.
    initial begin
        cmd_if.valid    = 1'b0;
        cmd_if.action   = ACT_NOP;
        cmd_if.pixel_x  = '0;
        cmd_if.pixel_y  = '0;
        cmd_if.red_in   = '0;
        cmd_if.green_in = '0;
        cmd_if.blue_in  = '0;
        leaf_if.ready   = 1'b0;
    end

    // Result side stalls at random; advance on the falling edge only.
    always @(negedge i_clk) begin
        leaf_if.ready <= ($urandom_range(99) >= take_idle_pct);
    end

    // Sample results at the rising edge and check them in order.
    always @(posedge i_clk) begin
        if (i_rst_n && leaf_if.valid && leaf_if.ready)
            sb.check_leaf('{leaf_if.leaf_valid, leaf_if.leaf_x, leaf_if.leaf_y,
                            leaf_if.leaf_width, leaf_if.leaf_height, leaf_if.mean_red,
                            leaf_if.mean_green, leaf_if.mean_blue, leaf_if.all_done});
    end

    // Guard against a hung block.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Offer one command item and hold it until the block takes it. Valid stays
    // high on return so that back-to-back items need no second assignment.
    task automatic send_command(logic [ACT_W-1:0] act, logic [7:0] x, logic [7:0] y,
                                logic [23:0] rgb);
        // move through the idling regimes as the run advances
        if (sb.commands >= 2 * ITEMS / 3) begin
            send_idle_pct = 0;
            take_idle_pct = 0;
        end else if (sb.commands >= ITEMS / 3) begin
            send_idle_pct = 78;
            take_idle_pct = 22;
        end
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_if.valid    <= 1'b1;
        cmd_if.action   <= act;
        cmd_if.pixel_x  <= x;
        cmd_if.pixel_y  <= y;
        cmd_if.red_in   <= rgb[23:16];
        cmd_if.green_in <= rgb[15:8];
        cmd_if.blue_in  <= rgb[7:0];
        do @(posedge i_clk); while (!cmd_if.ready);
        sb.note_command(act, x, y, rgb);
    endtask

    // Drop valid and wait until every predicted leaf has come back, then let
    // any load or start still in flight settle.
    task automatic drain();
        @(negedge i_clk);
        cmd_if.valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    // Raise the write enable for one rising edge, starting at the next falling edge.
    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    // Colour of a pixel for one of four image styles: noise, near-flat,
    // flat quadrants, and a black/white checkerboard.
    function automatic logic [23:0] paint(int style, int x, int y, int w, int h,
                                          logic [23:0] base);
        case (style)
            0: return 24'($urandom);
            1: return base ^ 24'($urandom_range(3));
            2: return (x < w / 2 ? base : ~base) ^ (y < h / 2 ? 24'h00_0000 : 24'h3C_5A_96);
            default: return ((x + y) % 2) ? 24'hFF_FFFF : 24'h00_0000;
        endcase
    endfunction

    // One pass: settle, configure, load the whole image, start, then fetch
    // leaves until the stack runs dry (at most max_fetch) and once more past it.
    task automatic run_pass(logic [8:0] w, logic [8:0] h, logic [8:0] lmin,
                            logic [6:0] thr, int style, int max_fetch);
        int unsigned sw, sh, fetched;
        logic [23:0] base;
        drain();
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_MIN_LEAF, lmin);
        write_reg(CFG_DEV_THRESH, {2'b00, thr});
        sw   = sb.clamp_side(w);
        sh   = sb.clamp_side(h);
        base = 24'($urandom);
        for (int y = 0; y < sh; y++)
            for (int x = 0; x < sw; x++)
                send_command(ACT_LOAD, 8'(x), 8'(y), paint(style, x, y, sw, sh, base));
        // stray loads anywhere in the store, reaching every coordinate bit
        repeat (2) send_command(ACT_LOAD, 8'($urandom), 8'($urandom), 24'($urandom));
        send_command(ACT_START, 8'($urandom), 8'($urandom), 24'($urandom));
        fetched = 0;
        do begin
            if ($urandom_range(99) < 8)
                send_command(ACT_NOP, 8'($urandom), 8'($urandom), 24'($urandom));
            if ($urandom_range(99) < 2) send_command(ACT_START, '0, '0, '0);
            send_command(ACT_FETCH, 8'($urandom), 8'($urandom), 24'($urandom));
            fetched++;
        end while (!sb.last_done && fetched < max_fetch);
        send_command(ACT_FETCH, '0, '0, '0);
    endtask

    initial begin
        logic [8:0] w, h, lmin;
        logic [6:0] thr;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: fetch on an empty stack, a no-op, then the corner settings.
        send_command(ACT_FETCH, '0, '0, '0);
        send_command(ACT_NOP, 8'hFF, 8'hFF, 24'hFF_FFFF);
        run_pass(9'd2,   9'd2, 9'd1,   7'd0,   3, 8);
        run_pass(9'd0,   9'd3, 9'd0,   7'd0,   0, 8);   // zero width saturates to one
        run_pass(9'd511, 9'd1, 9'd1,   7'd8,   0, 4);   // oversize width saturates
        run_pass(9'd4,   9'd4, 9'd0,   7'd127, 0, 8);   // huge threshold keeps the root
        run_pass(9'd4,   9'd4, 9'd511, 7'd0,   2, 8);   // huge leaf size keeps the root
        run_pass(9'd1,   9'd64, 9'd1,  7'd64,  1, 4);
        run_pass(9'd8,   9'd8, 9'd0,   7'd0,   3, 70);  // full split down to pixels

        // Random passes, mostly small images with thresholds that split.
        while (sb.commands < ITEMS) begin
            w    = 9'($urandom_range(1, 10));
            h    = 9'($urandom_range(1, 10));
            lmin = 9'($urandom_range(0, 3));
            thr  = 7'($urandom_range(0, 20));
            if ($urandom_range(9) == 0) begin
                w = $urandom_range(2) == 0 ? 9'd0 : 9'($urandom_range(256, 511));
                h = 9'($urandom_range(1, 2));
            end
            if ($urandom_range(9) == 0) lmin = 9'($urandom_range(0, 511));
            if ($urandom_range(9) == 0) thr = 7'($urandom_range(0, 127));
            run_pass(w, h, lmin, thr, $urandom_range(3), 40);
        end

        drain();
        repeat (200) @(negedge i_clk);
        if (sb.fails == 0 && sb.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
